FILE: hdl/gba_pkg.sv
package gba_pkg;

  localparam int GROUPS  = 8;
  localparam int GRP_W   = $clog2(GROUPS);
  localparam int GCNT_W  = $clog2(GROUPS + 1);
  localparam int BPG_MAX = 8192;
  localparam int IPG_MAX = 2048;
  localparam int WORD    = 32;
  localparam int BIT_W   = $clog2(WORD);
  localparam int BWPG    = BPG_MAX / WORD;
  localparam int IWPG    = IPG_MAX / WORD;
  localparam int BW_W    = $clog2(BWPG);
  localparam int IW_W    = $clog2(IWPG);
  localparam int BWORDS  = GROUPS * BWPG;
  localparam int IWORDS  = GROUPS * IWPG;
  localparam int BADDR_W = GRP_W + BW_W;
  localparam int IADDR_W = GRP_W + IW_W;
  localparam int BLEN_W  = 14;
  localparam int ILEN_W  = 12;
  localparam int NUM_W   = 17;
  localparam int CFG_W   = 14;
  localparam int FIRST_FREE_INODE = 11;
  localparam int START_W = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC_BLOCK = 2'd0,
    CMD_FREE_BLOCK  = 2'd1,
    CMD_ALLOC_INODE = 2'd2,
    CMD_FREE_INODE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOFREE = 2'd1,
    STS_RANGE  = 2'd2,
    STS_DOUBLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_GROUP_COUNT = 2'd0,
    REG_BLOCK_OFFSET = 2'd1,
    REG_BLOCKS_PER_GROUP = 2'd2,
    REG_INODES_PER_GROUP = 2'd3
  } reg_e;

endpackage

FILE: hdl/gba_word_scan.sv
module gba_word_scan (
  input  logic [gba_pkg::WORD-1:0]    word_i,
  input  logic [gba_pkg::BLEN_W-1:0]  base_i,
  input  logic [gba_pkg::BLEN_W-1:0]  len_i,
  input  logic [gba_pkg::START_W-1:0] start_i,
  output logic                        found_o,
  output logic [gba_pkg::BIT_W-1:0]   bit_o
);
  import gba_pkg::*;

  logic [WORD-1:0]   free_b;
  logic [BLEN_W-1:0] pos;

  always_comb begin
    pos = '0;
    for (int b = 0; b < WORD; b++) begin
      pos = base_i + BLEN_W'(b);
      free_b[b] = !word_i[b] && (pos < len_i) && (pos >= BLEN_W'(start_i));
    end
  end

  always_comb begin
    bit_o = '0;
    for (int b = WORD - 1; b >= 0; b--) begin
      if (free_b[b]) begin
        bit_o = BIT_W'(b);
      end
    end
  end

  assign found_o = |free_b;

endmodule

FILE: hdl/grouped_bitmap_allocator_core.sv
// Block and inode allocator over per-group bitmaps.
// Input channel (in_valid_i/in_ready_o) takes one command beat: allocate or
// free a block or an inode. Output channel (out_valid_o/out_ready_i) returns
// exactly one result beat per command, in order.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken; write them
// only while the block is idle.
// Both bitmaps sit in single-port-write RAMs read one word per cycle.
// An allocation scans one bitmap word per cycle; a block allocation scans its
// hint group first when that group exists, an inode allocation starts at group
// 0. Worst case 9 * 256 words for blocks (hint group, then every group). A free
// does a group search, a read-modify-write of one word, then a counter update
// and free-count sum over every configured group.
// One command is in work at a time; the next is taken once the result sits
// in the output register.
// Reset: a clearing pass writes every bitmap word to zero with in_ready_o low;
// configuration returns to its defaults at once.
// A stalled receiver holds the result; the block then finishes at most one
// more command and waits with it.
module grouped_bitmap_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [2:0]                 group_hint_i,
  input  logic [16:0]                number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [16:0]                allocated_o,
  output logic [2:0]                 group_o,
  output logic [13:0]                free_in_group_o,
  output logic [16:0]                free_total_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [gba_pkg::CFG_W-1:0]  cfg_data_i
);
  import gba_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FRD   = 3'd4;
  localparam logic [2:0] ST_FCHK  = 3'd5;
  localparam logic [2:0] ST_NUM   = 3'd6;
  localparam logic [2:0] ST_SUM   = 3'd7;

  // config
  logic [GCNT_W-1:0] gc_raw_q;
  logic              off_q;
  logic [BLEN_W-1:0] bpg_raw_q;
  logic [ILEN_W-1:0] ipg_raw_q;
  logic [GCNT_W-1:0] gc;
  logic [BLEN_W-1:0] bpg;
  logic [ILEN_W-1:0] ipg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_raw_q  <= GCNT_W'(GROUPS);
      off_q     <= 1'b1;
      bpg_raw_q <= BLEN_W'(BPG_MAX);
      ipg_raw_q <= ILEN_W'(IPG_MAX);
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_GROUP_COUNT:      gc_raw_q  <= cfg_data_i[GCNT_W-1:0];
        REG_BLOCK_OFFSET:     off_q     <= cfg_data_i[0];
        REG_BLOCKS_PER_GROUP: bpg_raw_q <= cfg_data_i[BLEN_W-1:0];
        REG_INODES_PER_GROUP: ipg_raw_q <= cfg_data_i[ILEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign gc  = (gc_raw_q == '0) ? GCNT_W'(1) :
               (gc_raw_q > GCNT_W'(GROUPS)) ? GCNT_W'(GROUPS) : gc_raw_q;
  assign bpg = (bpg_raw_q == '0) ? BLEN_W'(1) :
               (bpg_raw_q > BLEN_W'(BPG_MAX)) ? BLEN_W'(BPG_MAX) : bpg_raw_q;
  assign ipg = (ipg_raw_q == '0) ? ILEN_W'(1) :
               (ipg_raw_q > ILEN_W'(IPG_MAX)) ? ILEN_W'(IPG_MAX) : ipg_raw_q;

  // state
  logic [2:0]          st_q;
  logic                blk_q;
  logic [NUM_W-1:0]    rel_q;
  logic [GCNT_W-1:0]   fg_q;
  logic [GRP_W-1:0]    cg_q;
  logic [BW_W-1:0]     cw_q;
  logic                cph_q;
  logic                cact_q;
  logic                ev_q;
  logic [GRP_W-1:0]    eg_q;
  logic [BW_W-1:0]     ew_q;
  logic [BW_W+BIT_W-1:0] ai_q;
  logic                inc_q;
  logic                dec_q;
  logic [1:0]          sts_q;
  logic [NUM_W-1:0]    alloc_q;
  logic [GRP_W-1:0]    grp_q;
  logic [GCNT_W-1:0]   s_q;
  logic [NUM_W-1:0]    acc_q;
  logic [BLEN_W-1:0]   fig_q;
  logic [BADDR_W-1:0]  clr_q;
  logic [BLEN_W-1:0]   ub_q [GROUPS];
  logic [ILEN_W-1:0]   ui_q [GROUPS];

  // memories
  logic [WORD-1:0]    bmem [BWORDS];
  logic [WORD-1:0]    imem [IWORDS];
  logic               bwe, iwe;
  logic [BADDR_W-1:0] bwa, bra;
  logic [IADDR_W-1:0] iwa, ira;
  logic [WORD-1:0]    bwd, iwd, brd_q, ird_q;

  always_ff @(posedge clk_i) begin
    if (bwe) begin
      bmem[bwa] <= bwd;
    end
    brd_q <= bmem[bra];
  end

  always_ff @(posedge clk_i) begin
    if (iwe) begin
      imem[iwa] <= iwd;
    end
    ird_q <= imem[ira];
  end

  // scan datapath
  logic [BLEN_W-1:0]    lenk;
  logic [BW_W:0]        nwords;
  logic [WORD-1:0]      word;
  logic [14:0]          first;
  logic [START_W-1:0]   start;
  logic                 hit;
  logic [BIT_W-1:0]     hbit;
  logic                 last_w;

  assign lenk   = blk_q ? bpg : BLEN_W'(ipg);
  assign nwords = (BW_W+1)'((15'(lenk) + 15'(WORD - 1)) >> BIT_W);
  assign word   = blk_q ? brd_q : ird_q;
  assign first  = 15'(eg_q) * 15'(ipg);
  assign start  = (blk_q || first >= 15'(FIRST_FREE_INODE - 1)) ? '0 :
                  START_W'(15'(FIRST_FREE_INODE - 1) - first);
  assign last_w = ((BW_W+1)'(cw_q) + 1'b1) == nwords;

  gba_word_scan u_scan (
    .word_i  (word),
    .base_i  (BLEN_W'({ew_q, {BIT_W{1'b0}}})),
    .len_i   (lenk),
    .start_i (start),
    .found_o (hit),
    .bit_o   (hbit)
  );

  // counter pass
  logic [GRP_W-1:0]  si;
  logic [BLEN_W-1:0] u, unew, fcur;
  logic              s_last;

  assign si     = s_q[GRP_W-1:0];
  assign u      = blk_q ? ub_q[si] : BLEN_W'(ui_q[si]);
  assign s_last = (s_q + 1'b1) >= gc;
  always_comb begin
    unew = u;
    if (si == grp_q && inc_q) begin
      unew = u + 1'b1;
    end else if (si == grp_q && dec_q && u != '0) begin
      unew = u - 1'b1;
    end
    fcur = (lenk > unew) ? lenk - unew : '0;
  end

  // memory ports
  always_comb begin
    bwe = 1'b0;
    iwe = 1'b0;
    bwa = {eg_q, ew_q};
    iwa = {eg_q, ew_q[IW_W-1:0]};
    bwd = brd_q | (WORD'(1) << hbit);
    iwd = ird_q | (WORD'(1) << hbit);
    bra = {cg_q, cw_q};
    ira = {cg_q, cw_q[IW_W-1:0]};
    case (st_q)
      ST_CLEAR: begin
        bwe = 1'b1;
        iwe = clr_q < BADDR_W'(IWORDS);
        bwa = clr_q;
        iwa = clr_q[IADDR_W-1:0];
        bwd = '0;
        iwd = '0;
      end
      ST_SCAN: begin
        bwe = ev_q && hit && blk_q;
        iwe = ev_q && hit && !blk_q;
      end
      ST_FRD: begin
        bra = {fg_q[GRP_W-1:0], rel_q[BIT_W+BW_W-1:BIT_W]};
        ira = {fg_q[GRP_W-1:0], rel_q[BIT_W+IW_W-1:BIT_W]};
      end
      ST_FCHK: begin
        bwa = {fg_q[GRP_W-1:0], rel_q[BIT_W+BW_W-1:BIT_W]};
        iwa = {fg_q[GRP_W-1:0], rel_q[BIT_W+IW_W-1:BIT_W]};
        bwd = brd_q & ~(WORD'(1) << rel_q[BIT_W-1:0]);
        iwd = ird_q & ~(WORD'(1) << rel_q[BIT_W-1:0]);
        bwe = blk_q && brd_q[rel_q[BIT_W-1:0]];
        iwe = !blk_q && ird_q[rel_q[BIT_W-1:0]];
      end
      default: ;
    endcase
  end

  // output register
  logic            out_valid_q;
  logic [1:0]      out_sts_q;
  logic [NUM_W-1:0] out_alloc_q, out_tot_q;
  logic [GRP_W-1:0] out_grp_q;
  logic [BLEN_W-1:0] out_fig_q;
  logic            sum_done;

  assign sum_done = (st_q == ST_SUM) && s_last && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_done) begin
      out_sts_q   <= sts_q;
      out_alloc_q <= alloc_q;
      out_grp_q   <= grp_q;
      out_fig_q   <= (si == grp_q) ? fcur : fig_q;
      out_tot_q   <= acc_q + NUM_W'(fcur);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_sts_q;
  assign allocated_o     = out_alloc_q;
  assign group_o         = out_grp_q;
  assign free_in_group_o = out_fig_q;
  assign free_total_o    = out_tot_q;
  assign in_ready_o      = (st_q == ST_IDLE);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      clr_q  <= '0;
      ev_q   <= 1'b0;
      cact_q <= 1'b0;
      inc_q  <= 1'b0;
      dec_q  <= 1'b0;
      s_q    <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        ub_q[g] <= '0;
        ui_q[g] <= '0;
      end
    end else begin
      case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BADDR_W'(BWORDS - 1)) begin
            st_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            blk_q   <= !command_i[1];
            inc_q   <= 1'b0;
            dec_q   <= 1'b0;
            sts_q   <= STS_OK;
            alloc_q <= '0;
            grp_q   <= '0;
            s_q     <= '0;
            acc_q   <= '0;
            fig_q   <= '0;
            fg_q    <= '0;
            cw_q    <= '0;
            cg_q    <= '0;
            cph_q   <= 1'b0;
            cact_q  <= 1'b1;
            ev_q    <= 1'b0;
            case (cmd_e'(command_i))
              CMD_ALLOC_BLOCK: begin
                if (GCNT_W'(group_hint_i) < gc) begin
                  cph_q <= 1'b1;
                  cg_q  <= group_hint_i;
                  grp_q <= group_hint_i;
                end
                st_q <= ST_SCAN;
              end
              CMD_ALLOC_INODE: begin
                st_q <= ST_SCAN;
              end
              CMD_FREE_BLOCK: begin
                if (number_i < NUM_W'(off_q)) begin
                  sts_q <= STS_RANGE;
                  st_q  <= ST_SUM;
                end else begin
                  rel_q <= number_i - NUM_W'(off_q);
                  st_q  <= ST_DIV;
                end
              end
              default: begin
                if (number_i == '0) begin
                  sts_q <= STS_RANGE;
                  st_q  <= ST_SUM;
                end else begin
                  rel_q <= number_i - 1'b1;
                  st_q  <= ST_DIV;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (ev_q && hit) begin
            grp_q <= eg_q;
            ai_q  <= {ew_q, hbit};
            inc_q <= 1'b1;
            ev_q  <= 1'b0;
            st_q  <= ST_NUM;
          end else if (!cact_q) begin
            sts_q <= STS_NOFREE;
            ev_q  <= 1'b0;
            st_q  <= ST_SUM;
          end else begin
            ev_q <= 1'b1;
            eg_q <= cg_q;
            ew_q <= cw_q;
            if (!last_w) begin
              cw_q <= cw_q + 1'b1;
            end else begin
              cw_q <= '0;
              if (cph_q) begin
                cph_q <= 1'b0;
                cg_q  <= '0;
              end else if ((GCNT_W'(cg_q) + 1'b1) >= gc) begin
                cact_q <= 1'b0;
              end else begin
                cg_q <= cg_q + 1'b1;
              end
            end
          end
        end
        ST_NUM: begin
          if (blk_q) begin
            alloc_q <= NUM_W'(off_q) + NUM_W'(eg_q) * NUM_W'(bpg) + NUM_W'(ai_q);
          end else begin
            alloc_q <= NUM_W'(first) + NUM_W'(ai_q) + 1'b1;
          end
          st_q <= ST_SUM;
        end
        ST_DIV: begin
          if (fg_q >= gc) begin
            sts_q <= STS_RANGE;
            st_q  <= ST_SUM;
          end else if (rel_q >= NUM_W'(lenk)) begin
            rel_q <= rel_q - NUM_W'(lenk);
            fg_q  <= fg_q + 1'b1;
          end else begin
            st_q <= ST_FRD;
          end
        end
        ST_FRD: begin
          st_q <= ST_FCHK;
        end
        ST_FCHK: begin
          grp_q <= fg_q[GRP_W-1:0];
          if (bwe || iwe) begin
            dec_q <= 1'b1;
          end else begin
            sts_q <= STS_DOUBLE;
          end
          st_q <= ST_SUM;
        end
        ST_SUM: begin
          if (!s_last || sum_done) begin
            if (blk_q) begin
              ub_q[si] <= unew;
            end else begin
              ui_q[si] <= ILEN_W'(unew);
            end
            if (si == grp_q) begin
              fig_q <= fcur;
            end
            acc_q <= acc_q + NUM_W'(fcur);
            s_q   <= s_q + 1'b1;
            if (sum_done) begin
              st_q <= ST_IDLE;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SUM |-> s_q < gc)
    else $error("counter pass beyond group count");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_DIV |-> fg_q <= gc)
    else $error("group search overran");

  a_hit_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN && ev_q && hit) |-> (bwe || iwe))
    else $error("found bit not written back");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> !in_ready_o && !out_valid_o)
    else $error("activity during clearing pass");

endmodule
